### design/baseline_heading_and_pitch_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the baseline heading and pitch core
// Shared clocked assertion forms used by the core's checks.
// ---------------------------------------------------------------------------
`ifndef BASELINE_HEADING_AND_PITCH_CORE_MACROS_SVH
`define BASELINE_HEADING_AND_PITCH_CORE_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define BHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be seen outside reset.
`define BHP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### design/bhp_pkg.sv
// ---------------------------------------------------------------------------
// Baseline heading and pitch package
// Widths, angle constants and the arctangent table shared by the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhp_pkg;

  localparam int unsigned DefCordicStages = 20;
  localparam int unsigned MaxCordicStages = 32;

  localparam int unsigned TimeW  = 53;
  localparam int unsigned LatW   = 32;
  localparam int unsigned LonW   = 33;
  localparam int unsigned HgtW   = 40;
  localparam int unsigned DLatW  = LatW + 1;
  localparam int unsigned DLonW  = LonW + 1;
  localparam int unsigned DHgtW  = HgtW + 1;
  localparam int unsigned MagW   = 31;
  localparam int unsigned SqW    = 2 * MagW;
  localparam int unsigned RadW   = SqW + 1;
  localparam int unsigned RootW  = 32;
  localparam int unsigned IsqrtStages = RootW;

  // CORDIC datapath widths leave room for the gain of about 1.65.
  localparam int unsigned HeadW  = DLonW + 3;
  localparam int unsigned PitchW = DHgtW + 3;

  localparam int unsigned AccBits       = 30;
  localparam int unsigned AngleFracBits = 16;
  localparam int unsigned RoundShift    = AccBits - AngleFracBits;
  localparam int unsigned ZW            = AccBits + 4;
  localparam int unsigned ZrW           = ZW - RoundShift;
  localparam int unsigned HeadAngW      = 19;
  localparam int unsigned PitchAngW     = 18;

  localparam logic signed [ZW-1:0] PiQ30     = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] HalfPiQ30 = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0] RoundHalf = ZW'(64'sd1 << (RoundShift - 1));
  localparam logic signed [ZW-1:0] PiRounded = (PiQ30 + RoundHalf) >>> RoundShift;
  localparam logic signed [ZrW-1:0] AngleLim = PiRounded[ZrW-1:0];

  localparam logic [31:0] AtanQ30 [MaxCordicStages] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef struct packed {
    logic [TimeW-1:0]        sample_time;
    logic signed [DLatW-1:0] dlat;
    logic signed [DLonW-1:0] dlon;
    logic signed [DHgtW-1:0] dhs;
  } side_t;

endpackage

### design/bhp_isqrt.sv
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhp_isqrt (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [bhp_pkg::RadW-1:0]        rad_i,
  output logic [bhp_pkg::RootW-1:0]       root_o
);

  localparam int unsigned N    = bhp_pkg::IsqrtStages;
  localparam int unsigned RW   = 2 * N;
  localparam int unsigned RemW = N + 2;

  logic [RW-1:0]   rad_q  [N];
  logic [RemW-1:0] rem_q  [N];
  logic [N-1:0]    root_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0]   prev_rad;
    logic [RemW-1:0] prev_rem;
    logic [N-1:0]    prev_root;
    logic [RemW+1:0] rs;
    logic [RemW+1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign prev_rad  = RW'(rad_i);
      assign prev_rem  = '0;
      assign prev_root = '0;
    end else begin : g_next
      assign prev_rad  = rad_q[k-1];
      assign prev_rem  = rem_q[k-1];
      assign prev_root = root_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign rs    = {prev_rem, prev_rad[RW-1 -: 2]};
    assign trial = {2'b00, prev_root, 2'b01};
    assign ge    = (rs >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {prev_rad[RW-3:0], 2'b00};
        rem_q[k]  <= ge ? RemW'(rs - trial) : RemW'(rs);
        root_q[k] <= {prev_root[N-2:0], ge};
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

### design/bhp_cordic.sv
// ---------------------------------------------------------------------------
// Pipelined CORDIC arctangent
// Vectoring mode atan2(y, x), one micro-rotation per register stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhp_cordic #(
  parameter int unsigned W      = bhp_pkg::HeadW,
  parameter int unsigned STAGES = bhp_pkg::DefCordicStages
) (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [W-1:0]                     x_i,
  input  logic signed [W-1:0]                     y_i,
  output logic signed [bhp_pkg::HeadAngW-1:0]     angle_o
);

  localparam int unsigned ZW  = bhp_pkg::ZW;
  localparam int unsigned ZrW = bhp_pkg::ZrW;

  logic signed [W-1:0]  x_q    [STAGES+1];
  logic signed [W-1:0]  y_q    [STAGES+1];
  logic signed [ZW-1:0] z_q    [STAGES+1];
  logic                 zero_q [STAGES+1];
  logic signed [bhp_pkg::HeadAngW-1:0] angle_q;

  // Left half plane is folded over by a quarter turn first.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i[W-1]) begin
        if (!y_i[W-1]) begin
          x_q[0] <= y_i;
          y_q[0] <= -x_i;
          z_q[0] <= bhp_pkg::HalfPiQ30;
        end else begin
          x_q[0] <= -y_i;
          y_q[0] <= x_i;
          z_q[0] <= -bhp_pkg::HalfPiQ30;
        end
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [ZW-1:0] Atan = ZW'(bhp_pkg::AtanQ30[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][W-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + Atan;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - Atan;
        end
      end
    end
  end

  logic signed [ZW-1:0]  z_sum;
  logic signed [ZW-1:0]  z_shr;
  logic signed [ZrW-1:0] z_rnd;
  logic signed [ZrW-1:0] z_sat;

  always_comb begin
    z_sum = z_q[STAGES] + bhp_pkg::RoundHalf;
    z_shr = z_sum >>> bhp_pkg::RoundShift;
    z_rnd = z_shr[ZrW-1:0];
    if (z_rnd > bhp_pkg::AngleLim) begin
      z_sat = bhp_pkg::AngleLim;
    end else if (z_rnd < -bhp_pkg::AngleLim) begin
      z_sat = -bhp_pkg::AngleLim;
    end else begin
      z_sat = z_rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= zero_q[STAGES] ? '0 : z_sat[bhp_pkg::HeadAngW-1:0];
    end
  end

  assign angle_o = angle_q;

endmodule

### design/baseline_heading_and_pitch_core.sv
// ---------------------------------------------------------------------------
// Baseline heading and pitch core
// Heading and pitch of a two-antenna baseline from one pair of positions.
// ---------------------------------------------------------------------------
// Each slave transaction carries a time-matched pair of antenna positions;
// the core forms the front-minus-back differences and returns, one master
// transaction per input, the timestamp with heading = atan2(dlon, dlat) and
// pitch = atan2(horizontal length, dheight), both in radians with 16
// fraction bits. The horizontal length comes from a pipelined square root.
// The pipeline takes one transaction per clock cycle while s_axis_tready_o
// is high. A result passes the difference, magnitude, square and sum stages
// and the 32 root stages, then the CORDIC fold register, the CORDIC stages
// (20 by default) and the angle register, which run in parallel for heading
// and pitch, before it is loaded into the output register.
// The whole pipeline moves on one enable. The output register is backed by
// a single skid register, so while the receiver stalls the core still
// accepts input until the skid register fills; then s_axis_tready_o drops
// and every stage holds. Reset clears the valid bits of the pipeline, the
// output register and the skid register; the datapath registers need no reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "baseline_heading_and_pitch_core_macros.svh"

module baseline_heading_and_pitch_core #(
  parameter int unsigned CORDIC_STAGES = bhp_pkg::DefCordicStages
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // sample_time[52:0], front_lat[84:53], front_lon[117:85],
  // front_height[157:118], back_lat[189:158], back_lon[222:190],
  // back_height[262:223], zero pad[263]
  input  logic [263:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // result_time[52:0], heading_angle[71:53], pitch_angle[89:72], zero pad[95:90]
  output logic [95:0]  m_axis_tdata_o
);

  localparam int unsigned SideN  = 2 + bhp_pkg::IsqrtStages;
  localparam int unsigned CordL  = CORDIC_STAGES + 2;
  localparam int unsigned Lat    = 4 + bhp_pkg::IsqrtStages + CordL;
  localparam int unsigned TimeW  = bhp_pkg::TimeW;
  localparam int unsigned OutW   = TimeW + bhp_pkg::HeadAngW + bhp_pkg::PitchAngW;

  typedef struct packed {
    logic [TimeW-1:0]                       result_time;
    logic signed [bhp_pkg::HeadAngW-1:0]    heading_angle;
    logic [bhp_pkg::PitchAngW-1:0]          pitch_angle;
  } result_t;

  logic en;
  logic [Lat-1:0] valid_q;

  // Stage 1: differences.
  logic [TimeW-1:0]                 time1_q;
  logic signed [bhp_pkg::DLatW-1:0] dlat1_q;
  logic signed [bhp_pkg::DLonW-1:0] dlon1_q;
  logic signed [bhp_pkg::DHgtW-1:0] dh1_q;

  // Stage 2: magnitudes scaled below 2^31, signed height difference.
  bhp_pkg::side_t          side2_q;
  logic [bhp_pkg::MagW-1:0] mlat2_q;
  logic [bhp_pkg::MagW-1:0] mlon2_q;

  // Stage 3 and 4: squares and their sum.
  logic [bhp_pkg::SqW-1:0]  sqlat3_q;
  logic [bhp_pkg::SqW-1:0]  sqlon3_q;
  logic [bhp_pkg::RadW-1:0] sum4_q;

  bhp_pkg::side_t   side_q [SideN];
  logic [TimeW-1:0] tdel_q [CordL];

  assign en = s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[Lat-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      time1_q <= s_axis_tdata_i[52:0];
      dlat1_q <= bhp_pkg::DLatW'($signed(s_axis_tdata_i[84:53]))
               - bhp_pkg::DLatW'($signed(s_axis_tdata_i[189:158]));
      dlon1_q <= bhp_pkg::DLonW'($signed(s_axis_tdata_i[117:85]))
               - bhp_pkg::DLonW'($signed(s_axis_tdata_i[222:190]));
      dh1_q   <= bhp_pkg::DHgtW'($signed(s_axis_tdata_i[157:118]))
               - bhp_pkg::DHgtW'($signed(s_axis_tdata_i[262:223]));
    end
  end

  // The smallest common shift that brings both horizontal magnitudes below
  // 2^31 is applied to all three magnitudes, truncating.
  logic [bhp_pkg::DLatW-1:0] alat;
  logic [bhp_pkg::DLonW-1:0] alon;
  logic [bhp_pkg::DHgtW-1:0] ah;
  logic [1:0]                 shamt;
  logic [bhp_pkg::DLatW-1:0] alat_s;
  logic [bhp_pkg::DLonW-1:0] alon_s;
  logic [bhp_pkg::DHgtW-1:0] ah_s;

  always_comb begin
    alat = dlat1_q[bhp_pkg::DLatW-1] ? -dlat1_q : dlat1_q;
    alon = dlon1_q[bhp_pkg::DLonW-1] ? -dlon1_q : dlon1_q;
    ah   = dh1_q[bhp_pkg::DHgtW-1] ? -dh1_q : dh1_q;
    if ((alat >> 31) == '0 && (alon >> 31) == '0) begin
      shamt = 2'd0;
    end else if ((alat >> 32) == '0 && (alon >> 32) == '0) begin
      shamt = 2'd1;
    end else begin
      shamt = 2'd2;
    end
    alat_s = alat >> shamt;
    alon_s = alon >> shamt;
    ah_s   = ah >> shamt;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q.sample_time <= time1_q;
      side2_q.dlat        <= dlat1_q;
      side2_q.dlon        <= dlon1_q;
      side2_q.dhs         <= dh1_q[bhp_pkg::DHgtW-1] ? -$signed(ah_s) : $signed(ah_s);
      mlat2_q             <= alat_s[bhp_pkg::MagW-1:0];
      mlon2_q             <= alon_s[bhp_pkg::MagW-1:0];
      sqlat3_q            <= mlat2_q * mlat2_q;
      sqlon3_q            <= mlon2_q * mlon2_q;
      sum4_q              <= bhp_pkg::RadW'(sqlat3_q) + bhp_pkg::RadW'(sqlon3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side2_q;
      for (int unsigned k = 1; k < SideN; k++) begin
        side_q[k] <= side_q[k-1];
      end
      tdel_q[0] <= side_q[SideN-1].sample_time;
      for (int unsigned k = 1; k < CordL; k++) begin
        tdel_q[k] <= tdel_q[k-1];
      end
    end
  end

  logic [bhp_pkg::RootW-1:0] root;

  bhp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum4_q),
    .root_o (root)
  );

  logic signed [bhp_pkg::HeadAngW-1:0] heading;
  logic signed [bhp_pkg::HeadAngW-1:0] pitch_full;

  bhp_cordic #(
    .W      (bhp_pkg::HeadW),
    .STAGES (CORDIC_STAGES)
  ) u_heading (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (bhp_pkg::HeadW'(side_q[SideN-1].dlat)),
    .y_i     (bhp_pkg::HeadW'(side_q[SideN-1].dlon)),
    .angle_o (heading)
  );

  bhp_cordic #(
    .W      (bhp_pkg::PitchW),
    .STAGES (CORDIC_STAGES)
  ) u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (bhp_pkg::PitchW'(side_q[SideN-1].dhs)),
    .y_i     ($signed(bhp_pkg::PitchW'(root))),
    .angle_o (pitch_full)
  );

  // Tail of the pipeline; pitch below zero is clamped.
  result_t tail;
  logic    tail_v;

  always_comb begin
    tail.result_time   = tdel_q[CordL-1];
    tail.heading_angle = heading;
    tail.pitch_angle   = pitch_full[bhp_pkg::HeadAngW-1] ? '0
                       : pitch_full[bhp_pkg::PitchAngW-1:0];
    tail_v             = valid_q[Lat-1];
  end

  // Output register with one skid register behind it.
  result_t out_q, skid_q;
  logic    out_v_q, skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (tail_v) begin
      if (!out_v_q || m_axis_tready_i) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready_i) begin
        out_q <= skid_q;
      end
    end else if (tail_v) begin
      if (!out_v_q || m_axis_tready_i) begin
        out_q <= tail;
      end else begin
        skid_q <= tail;
      end
    end
  end

  assign s_axis_tready_o = !skid_v_q;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {(96 - OutW)'(0), out_q.pitch_angle, out_q.heading_angle,
                            out_q.result_time};

  `BHP_ASSERT(a_skid_needs_out, skid_v_q |-> out_v_q, "skid register full with output empty")
  `BHP_ASSERT(a_skid_on_stall, $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready_i), "skid filled without a stall")
  `BHP_NEVER(a_heading_range, out_v_q && (out_q.heading_angle > bhp_pkg::HeadAngW'(bhp_pkg::AngleLim) || out_q.heading_angle < -bhp_pkg::HeadAngW'(bhp_pkg::AngleLim)), "heading out of range")
  `BHP_NEVER(a_pitch_range, out_v_q && (out_q.pitch_angle > bhp_pkg::PitchAngW'(bhp_pkg::AngleLim)), "pitch out of range")

endmodule
